@@ hdl/crcce_pkg.sv @@
// Package for the CRC codeword encoder: field widths, register indexes,
// reset values and pipeline shape constants.
// No dependencies.
package crcce_pkg;

    // Payload and register widths.
    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int POLY_W   = 17;
    localparam int GLEN_W   = 5;
    localparam int CW_W     = 24;
    localparam int CWLEN_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Default for the longest generator the block supports.
    localparam int DEF_MAX_GEN_LEN = 17;

    // Smallest generator length; shorter settings are raised to this.
    localparam int MIN_GEN_LEN = 2;

    // Dataword sizes in bits.
    localparam int DW_SHORT = 4;
    localparam int DW_LONG  = 8;

    // Division pipeline: bits of the dataword retired per stage.
    localparam int BITS_PER_STAGE = 2;
    localparam int N_CRC_STAGES   = BYTE_W / BITS_PER_STAGE;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATAWORD_MODE = 2'd2;

    // Register reset values.
    localparam logic [POLY_W-1:0] RST_GEN_POLY   = 17'd11;
    localparam logic [GLEN_W-1:0] RST_GEN_LENGTH = 5'd4;
    localparam logic              RST_MODE       = 1'b0;

    // Dataword mode codes.
    localparam logic MODE_NIBBLE = 1'b0;
    localparam logic MODE_BYTE   = 1'b1;

endpackage

@@ hdl/crc_codeword_encoder.sv @@
// CRC codeword encoder top level: byte splitter, pipelined modulo-2 divider
// and output register. Depends on crcce_pkg.
//
// Each accepted byte is encoded into one codeword (8-bit dataword mode) or
// two codewords (4-bit mode, high nibble first, then low nibble). A codeword
// is the dataword followed by the remainder of dividing the dataword, with
// gen_length-1 zero bits appended, by the configured generator polynomial;
// the leading generator term is implied. Settings of gen_length below 2 act
// as 2 and settings above MAX_GEN_LEN act as MAX_GEN_LEN. The block is a
// six-stage pipeline: a splitter register that issues one dataword per cycle
// while the first division stage can load, four division stages that each
// retire two dataword bits, and an output register that assembles the
// codeword. In 8-bit mode a new byte is taken every cycle while the output
// side does not stall; in 4-bit mode a byte is held until both nibbles issue,
// since the splitter feeds both nibbles through the single division pipeline
// and the single result port. Empty stages are filled while the output is
// stalled, so the input keeps accepting until the pipeline is full. Both
// channels use a valid/ready handshake; each transaction on the output
// carries a last flag that marks the final codeword of its byte. The
// configuration registers must only be written while no transaction is in
// flight.
module crc_codeword_encoder #(
    parameter int MAX_GEN_LEN = crcce_pkg::DEF_MAX_GEN_LEN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_wr_en,
    input  logic [crcce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [crcce_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [crcce_pkg::BYTE_W-1:0]       i_data_byte,
    // Output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [crcce_pkg::CW_W-1:0]         o_codeword,
    output logic [crcce_pkg::CWLEN_W-1:0]      o_codeword_length,
    output logic                               o_last
);

    // Remainder width, width of the remainder length, and bit index width.
    localparam int RW = MAX_GEN_LEN - 1;
    localparam int MW = $clog2(MAX_GEN_LEN);
    localparam int IW = (RW > 1) ? $clog2(RW) : 1;
    // Width wide enough for the clamped generator length and the raw setting.
    localparam int GW = ($clog2(MAX_GEN_LEN + 1) > crcce_pkg::GLEN_W) ?
                        $clog2(MAX_GEN_LEN + 1) : crcce_pkg::GLEN_W;
    // Full codeword width before truncation to the output field.
    localparam int WF = (crcce_pkg::BYTE_W + RW > crcce_pkg::CW_W) ?
                        crcce_pkg::BYTE_W + RW : crcce_pkg::CW_W;
    localparam int NS  = crcce_pkg::N_CRC_STAGES;
    localparam int BPS = crcce_pkg::BITS_PER_STAGE;
    localparam int BW  = crcce_pkg::BYTE_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [crcce_pkg::POLY_W-1:0] r_poly;
    logic [crcce_pkg::GLEN_W-1:0] r_glen;
    logic                         r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= crcce_pkg::RST_GEN_POLY;
            r_glen <= crcce_pkg::RST_GEN_LENGTH;
            r_mode <= crcce_pkg::RST_MODE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                crcce_pkg::REG_GEN_POLY: begin
                    r_poly <= i_cfg_wdata[crcce_pkg::POLY_W-1:0];
                end
                crcce_pkg::REG_GEN_LENGTH: begin
                    r_glen <= i_cfg_wdata[crcce_pkg::GLEN_W-1:0];
                end
                crcce_pkg::REG_DATAWORD_MODE: begin
                    r_mode <= i_cfg_wdata[0];
                end
                default: begin
                    // Unknown index: the write is dropped.
                end
            endcase
        end
    end

    // Derived divisor terms. Users must write registers only while the block
    // is idle, unchecked by the block, so every stage may use them directly.
    logic [GW-1:0] glen_ext;
    logic [GW-1:0] glen_eff;
    logic [MW-1:0] rem_len;
    logic [RW-1:0] rem_mask;
    logic [RW-1:0] poly_low;

    always_comb begin
        glen_ext = GW'(r_glen);
        if (glen_ext < GW'(crcce_pkg::MIN_GEN_LEN)) begin
            glen_eff = GW'(crcce_pkg::MIN_GEN_LEN);
        end else if (glen_ext > GW'(MAX_GEN_LEN)) begin
            glen_eff = GW'(MAX_GEN_LEN);
        end else begin
            glen_eff = glen_ext;
        end
        rem_len  = MW'(glen_eff - GW'(1));
        rem_mask = ~({RW{1'b1}} << rem_len);
        poly_low = RW'(r_poly) & rem_mask;
    end

    // One step of the division: shift in one dataword bit, MSB first.
    function automatic logic [RW-1:0] div_step(
        input logic [RW-1:0] rem,
        input logic          din,
        input logic [MW-1:0] m,
        input logic [RW-1:0] mask,
        input logic [RW-1:0] low
    );
        logic          fb;
        logic [RW-1:0] nxt;
        fb  = din ^ rem[IW'(m - MW'(1))];
        nxt = (rem << 1) & mask;
        if (fb) begin
            nxt = nxt ^ low;
        end
        return nxt;
    endfunction

    // ------------------------------------------------------------------
    // Handshake enables. A stage loads when it is empty or when the stage
    // after it loads in the same cycle.
    // ------------------------------------------------------------------
    logic          r_out_vld;
    logic [NS-1:0] r_cs_vld;
    logic          out_en;
    logic [NS:0]   cs_en;

    always_comb begin
        out_en    = !r_out_vld || i_out_ready;
        cs_en[NS] = out_en;
        for (int k = NS - 1; k >= 0; k--) begin
            cs_en[k] = !r_cs_vld[k] || cs_en[k+1];
        end
    end

    // ------------------------------------------------------------------
    // Splitter stage: holds the byte, issues one dataword per unstalled cycle.
    // ------------------------------------------------------------------
    logic          r_s0_vld;
    logic [BW-1:0] r_s0_byte;
    logic          r_s0_mode;
    logic          r_s0_phase;
    logic          s0_issue;
    logic          s0_done;
    logic [BW-1:0] s0_word;
    logic          s0_last;

    always_comb begin
        s0_issue = r_s0_vld && cs_en[0];
        s0_last  = (r_s0_mode == crcce_pkg::MODE_BYTE) || r_s0_phase;
        s0_done  = s0_issue && s0_last;
        if (r_s0_mode == crcce_pkg::MODE_BYTE) begin
            s0_word = r_s0_byte;
        end else if (r_s0_phase) begin
            s0_word = BW'(r_s0_byte[crcce_pkg::NIB_W-1:0]);
        end else begin
            s0_word = BW'(r_s0_byte[BW-1:crcce_pkg::NIB_W]);
        end
    end

    assign o_in_ready = !r_s0_vld || s0_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld   <= 1'b0;
            r_s0_phase <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_s0_vld   <= 1'b1;
            r_s0_phase <= 1'b0;
        end else if (s0_done) begin
            r_s0_vld   <= 1'b0;
        end else if (s0_issue) begin
            r_s0_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s0_byte <= i_data_byte;
            r_s0_mode <= r_mode;
        end
    end

    // ------------------------------------------------------------------
    // Division stages. Stage k retires dataword bits from the top down. A
    // short dataword rides zero-extended: leading zero bits leave the
    // remainder at zero, so the result matches a four-step division.
    // ------------------------------------------------------------------
    logic [BW-1:0] r_cs_word [NS];
    logic          r_cs_mode [NS];
    logic          r_cs_last [NS];
    logic [RW-1:0] r_cs_rem  [NS];

    logic          st_vld  [NS];
    logic [BW-1:0] st_word [NS];
    logic          st_mode [NS];
    logic          st_last [NS];
    logic [RW-1:0] st_rem  [NS];
    logic [RW-1:0] n_cs_rem [NS];

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                st_vld[k]  = r_s0_vld;
                st_word[k] = s0_word;
                st_mode[k] = r_s0_mode;
                st_last[k] = s0_last;
                st_rem[k]  = '0;
            end else begin
                st_vld[k]  = r_cs_vld[k-1];
                st_word[k] = r_cs_word[k-1];
                st_mode[k] = r_cs_mode[k-1];
                st_last[k] = r_cs_last[k-1];
                st_rem[k]  = r_cs_rem[k-1];
            end
            n_cs_rem[k] = st_rem[k];
            for (int j = 0; j < BPS; j++) begin
                n_cs_rem[k] = div_step(n_cs_rem[k], st_word[k][BW-1-BPS*k-j],
                                       rem_len, rem_mask, poly_low);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (cs_en[k]) begin
                    r_cs_vld[k] <= st_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (cs_en[k]) begin
                r_cs_word[k] <= st_word[k];
                r_cs_mode[k] <= st_mode[k];
                r_cs_last[k] <= st_last[k];
                r_cs_rem[k]  <= n_cs_rem[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: places the dataword above the remainder.
    // ------------------------------------------------------------------
    logic [WF-1:0]                  cw_full;
    logic [MW+3:0]                  len_full;
    logic [crcce_pkg::CW_W-1:0]     r_out_cw;
    logic [crcce_pkg::CWLEN_W-1:0]  r_out_len;
    logic                           r_out_last;

    always_comb begin
        cw_full = (WF'(r_cs_word[NS-1]) << rem_len) | WF'(r_cs_rem[NS-1]);
        if (r_cs_mode[NS-1] == crcce_pkg::MODE_BYTE) begin
            len_full = (MW+4)'(crcce_pkg::DW_LONG) + (MW+4)'(rem_len);
        end else begin
            len_full = (MW+4)'(crcce_pkg::DW_SHORT) + (MW+4)'(rem_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= r_cs_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_cw   <= cw_full[crcce_pkg::CW_W-1:0];
            r_out_len  <= len_full[crcce_pkg::CWLEN_W-1:0];
            r_out_last <= r_cs_last[NS-1];
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_codeword        = r_out_cw;
    assign o_codeword_length = r_out_len;
    assign o_last            = r_out_last;

endmodule

@@ verif/crc_codeword_checker.sv @@
// Checker for the CRC codeword encoder: tracks register writes, predicts the
// codewords of every accepted byte and compares them with the result channel.
// Depends on crcce_pkg.
module crc_codeword_checker #(
    parameter int MAX_GEN_LEN = crcce_pkg::DEF_MAX_GEN_LEN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [crcce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crcce_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [crcce_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [crcce_pkg::CW_W-1:0]        i_codeword,
    input  logic [crcce_pkg::CWLEN_W-1:0]     i_codeword_length,
    input  logic                              i_last,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_codewords_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [crcce_pkg::CW_W-1:0]    codeword;
        logic [crcce_pkg::CWLEN_W-1:0] cw_len;
        logic                          last;
    } t_codeword;

    t_codeword                        expected_codewords[$];
    logic [crcce_pkg::POLY_W-1:0]     gen_poly  = crcce_pkg::RST_GEN_POLY;
    logic [crcce_pkg::GLEN_W-1:0]     gen_len   = crcce_pkg::RST_GEN_LENGTH;
    logic                             word_mode = crcce_pkg::RST_MODE;
    int                               mismatch_count = 0;
    int                               pending_count  = 0;
    int                               seen_count     = 0;

    assign o_mismatches     = mismatch_count;
    assign o_pending        = pending_count;
    assign o_codewords_seen = seen_count;

    // Long division of the dataword, shifted up by the remainder width, by the
    // generator with its leading term implied.
    function automatic t_codeword encode_dataword(
        input logic [crcce_pkg::BYTE_W-1:0] word,
        input int                           dbits,
        input logic                         last_flag
    );
        int          glen_eff;
        int          m;
        logic [63:0] low;
        logic [63:0] shifted;
        logic [63:0] rem;
        t_codeword   res;
        glen_eff = int'(gen_len);
        if (glen_eff < crcce_pkg::MIN_GEN_LEN) glen_eff = crcce_pkg::MIN_GEN_LEN;
        if (glen_eff > MAX_GEN_LEN) glen_eff = MAX_GEN_LEN;
        m = glen_eff - 1;
        low = {47'd0, gen_poly} & ((64'd1 << m) - 64'd1);
        shifted = {56'd0, word} << m;
        rem = shifted;
        for (int pos = dbits + m - 1; pos >= m; pos--) begin
            if (rem[pos]) rem = rem ^ ((64'd1 << pos) | (low << (pos - m)));
        end
        rem = rem & ((64'd1 << m) - 64'd1);
        res.codeword = crcce_pkg::CW_W'(shifted | rem);
        res.cw_len = crcce_pkg::CWLEN_W'(dbits + m);
        res.last = last_flag;
        return res;
    endfunction

    // Appends one predicted codeword at the tail of the expected queue.
    task automatic queue_expected(input t_codeword item);
        expected_codewords = {expected_codewords, item};
    endtask

    task automatic check_codeword();
        t_codeword got;
        t_codeword want;
        got.codeword = i_codeword;
        got.cw_len = i_codeword_length;
        got.last = i_last;
        seen_count++;
        if (expected_codewords.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("[%0t] unexpected codeword %06h len %0d last %0b",
                         $realtime, got.codeword, got.cw_len, got.last);
        end else begin
            want = expected_codewords.pop_front();
            if (got.codeword !== want.codeword || got.cw_len !== want.cw_len ||
                got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] expected %06h len %0d last %0b, got %06h len %0d last %0b",
                             $realtime, want.codeword, want.cw_len, want.last,
                             got.codeword, got.cw_len, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gen_poly  <= crcce_pkg::RST_GEN_POLY;
            gen_len   <= crcce_pkg::RST_GEN_LENGTH;
            word_mode <= crcce_pkg::RST_MODE;
            expected_codewords.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_codeword();
            if (i_in_valid && i_in_ready) begin
                if (word_mode == crcce_pkg::MODE_BYTE) begin
                    queue_expected(encode_dataword(i_data_byte, crcce_pkg::DW_LONG, 1'b1));
                end else begin
                    queue_expected(encode_dataword({4'd0, i_data_byte[7:4]},
                                                   crcce_pkg::DW_SHORT, 1'b0));
                    queue_expected(encode_dataword({4'd0, i_data_byte[3:0]},
                                                   crcce_pkg::DW_SHORT, 1'b1));
                end
            end
            // Writes to an index outside the register map are dropped.
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    crcce_pkg::REG_GEN_POLY:      gen_poly  <= i_cfg_wdata[crcce_pkg::POLY_W-1:0];
                    crcce_pkg::REG_GEN_LENGTH:    gen_len   <= i_cfg_wdata[crcce_pkg::GLEN_W-1:0];
                    crcce_pkg::REG_DATAWORD_MODE: word_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pending_count = expected_codewords.size();
    end

endmodule

@@ verif/tb_crc_codeword_encoder.sv @@
// Testbench top for the CRC codeword encoder: clock, reset, register writes,
// byte stimulus, result-side back-pressure and the final verdict.
// Depends on crcce_pkg, crc_codeword_encoder and crc_codeword_checker.
module tb_crc_codeword_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    // Index that no register answers to; writes there must be dropped.
    localparam logic [crcce_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RESET_CYCLES       = 9;
    localparam int DRAIN_CYCLES       = 12;
    localparam int STALL_BURST_CYCLES = 80;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int N_PHASES           = 3;
    localparam int BLOCKS_PER_PHASE   = 6;
    localparam int BYTES_PER_BLOCK    = 24;
    localparam int PRESSURE_BLOCK     = 2;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 cfg_wr_en = 1'b0;
    logic [crcce_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [crcce_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [crcce_pkg::BYTE_W-1:0]         data_byte = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [crcce_pkg::CW_W-1:0]           codeword;
    logic [crcce_pkg::CWLEN_W-1:0]        codeword_length;
    logic                                 last;

    int mismatches;
    int pending;
    int codewords_seen;

    // Idle percentages for each side; the stimulus process changes them per phase.
    int send_idle_pct = 16;
    int recv_idle_pct = 52;
    // The stimulus process counts requested hold-off bursts, the receiver
    // counts the ones it has served; a difference starts a new burst.
    int stall_bursts_req  = 0;
    int stall_bursts_done = 0;

    int bytes_sent = 0;
    int settings_applied = 0;
    int quiet_cycles = 0;

    crc_codeword_encoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_data_byte       (data_byte),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_codeword        (codeword),
        .o_codeword_length (codeword_length),
        .o_last            (last)
    );

    crc_codeword_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_data_byte       (data_byte),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_codeword        (codeword),
        .i_codeword_length (codeword_length),
        .i_last            (last),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_codewords_seen  (codewords_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one byte and hold it until the encoder takes it. Random idle cycles
    // go in front of the transaction; valid is never dropped once raised, and the
    // task returns at the edge where the byte was accepted so that the next call
    // can keep valid high for back-to-back transactions.
    task automatic send_byte(input logic [crcce_pkg::BYTE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Stop offering bytes and wait until every predicted codeword has come out,
    // then give the pipeline a few more cycles so any stray result would show.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Program all three registers plus one write to the unused index. The upper
    // bits of the length and mode words carry random junk that must be ignored.
    task automatic apply_settings(input logic [crcce_pkg::POLY_W-1:0] poly,
                                  input logic [crcce_pkg::GLEN_W-1:0] glen,
                                  input logic mode);
        logic [crcce_pkg::CFG_DATA_W-1:0] glen_word;
        logic [crcce_pkg::CFG_DATA_W-1:0] mode_word;
        glen_word = crcce_pkg::CFG_DATA_W'($urandom());
        glen_word[crcce_pkg::GLEN_W-1:0] = glen;
        mode_word = crcce_pkg::CFG_DATA_W'($urandom());
        mode_word[0] = mode;
        cfg_wr_en <= 1'b1;
        cfg_index <= crcce_pkg::REG_GEN_POLY;
        cfg_wdata <= poly;
        @(posedge i_clk);
        cfg_index <= crcce_pkg::REG_GEN_LENGTH;
        cfg_wdata <= glen_word;
        @(posedge i_clk);
        cfg_index <= crcce_pkg::REG_DATAWORD_MODE;
        cfg_wdata <= mode_word;
        @(posedge i_clk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= crcce_pkg::CFG_DATA_W'($urandom());
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // Result-side ready. A long hold-off burst is counted here so the sender
    // keeps offering bytes while the pipeline fills and the input stalls.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_bursts_done != stall_bursts_req) begin
                stall_bursts_done++;
                out_ready <= 1'b0;
                repeat (STALL_BURST_CYCLES - 1) @(posedge i_clk);
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [crcce_pkg::POLY_W-1:0] poly;
        logic [crcce_pkg::GLEN_W-1:0] glen;
        logic                         mode;
        int                           pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The first bytes run on the reset values of the
        // registers, covering all-zero, all-one and alternating patterns in
        // nibble mode.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h80);
        send_byte(8'h01);
        drain();

        // A generator length below the minimum acts as the minimum.
        apply_settings(crcce_pkg::POLY_W'($urandom()), 5'd0, crcce_pkg::MODE_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h81);
        drain();

        // The largest length setting clamps to the longest generator, giving
        // the widest codeword; an all-ones polynomial sets the implied term too.
        apply_settings({crcce_pkg::POLY_W{1'b1}}, 5'd31, crcce_pkg::MODE_BYTE);
        send_byte(8'hFF);
        send_byte(8'h7E);
        drain();

        // Longest legal generator with only the implied term in nibble mode.
        apply_settings('0, 5'd17, crcce_pkg::MODE_NIBBLE);
        send_byte(8'hFF);
        send_byte(8'h01);
        drain();

        // Length one is raised to two; all the upper polynomial bits are ignored.
        apply_settings({crcce_pkg::POLY_W{1'b1}}, 5'd1, crcce_pkg::MODE_NIBBLE);
        send_byte(8'hC3);
        drain();

        apply_settings(17'd1, 5'd2, crcce_pkg::MODE_BYTE);
        send_byte(8'h55);
        drain();

        // Just above the longest generator.
        apply_settings(crcce_pkg::POLY_W'($urandom()), 5'd18, crcce_pkg::MODE_NIBBLE);
        send_byte(8'hAA);
        drain();

        // Random part: three idling profiles, each going through several
        // register settings. The first two blocks of every phase pin the
        // generator length at its legal extremes.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 16;
                    recv_idle_pct = 52;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_idle_pct = 16;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
                poly = crcce_pkg::POLY_W'($urandom());
                mode = logic'($urandom_range(1));
                pick = $urandom_range(9);
                if (blk == 0)
                    glen = 5'd17;
                else if (blk == 1)
                    glen = 5'd2;
                else if (pick == 0)
                    glen = crcce_pkg::GLEN_W'($urandom_range(1));
                else if (pick == 1)
                    glen = crcce_pkg::GLEN_W'($urandom_range(31, 18));
                else
                    glen = crcce_pkg::GLEN_W'($urandom_range(17, 2));
                apply_settings(poly, glen, mode);
                // One block per phase runs into a long result-side hold-off.
                if (blk == PRESSURE_BLOCK) stall_bursts_req++;
                for (int n = 0; n < BYTES_PER_BLOCK; n++)
                    send_byte(crcce_pkg::BYTE_W'($urandom_range(255)));
                drain();
            end
        end

        $display("Encoded %0d bytes into %0d codewords over %0d register settings,",
                 bytes_sent, codewords_seen, settings_applied);
        $display("with clamped generator lengths, both dataword sizes and long output stalls.");
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
